FILE: rtl/core/tcd_pkg.sv
// Shared types and range constants for the timestamp to civil date pipeline.
`default_nettype none

package tcd_pkg;

  // Day count shifted to the March-based epoch (days since 0000-03-01)
  localparam int unsigned DaysW = 20;
  typedef logic [DaysW-1:0] days_t;

  typedef logic [11:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  mday_t;

  // Bounds on the shifted day count over every 64-bit nanosecond value
  localparam days_t ShiftedDaysMin = days_t'(612716);
  localparam days_t ShiftedDaysMax = days_t'(826221);

  localparam year_t YearMin = year_t'(1677);
  localparam year_t YearMax = year_t'(2262);

endpackage : tcd_pkg

`default_nettype wire

FILE: rtl/core/tcd_day_div.sv
// Floor division of signed nanoseconds into days, shifted to the March-based epoch.
`default_nettype none

module tcd_day_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [63:0]    time_ns_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcd_pkg::days_t days_o
);
  import tcd_pkg::*;

  // 86400e9 = 2^16 * 1318359375; the power of two goes as an arithmetic shift
  localparam int unsigned NsShift    = 16;
  localparam logic [30:0] NsDivisor  = 31'd1318359375;
  localparam logic [19:0] EpochShift = 20'd719468;
  // Epoch shift folded into the dividend so that it is never negative
  localparam logic [49:0] EpochOffset = 50'(EpochShift) * 50'(NsDivisor);
  localparam int unsigned RecipShift = 52;
  localparam logic [21:0] DayRecip   = 22'((64'd1 << RecipShift) / NsDivisor);

  logic [3:0] valid_q;
  logic       rdy0, rdy1, rdy2, rdy3;

  assign rdy3 = !valid_q[3] || out_ready_i;
  assign rdy2 = !valid_q[2] || rdy3;
  assign rdy1 = !valid_q[1] || rdy2;
  assign rdy0 = !valid_q[0] || rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy0) valid_q[0] <= in_valid_i;
      if (rdy1) valid_q[1] <= valid_q[0];
      if (rdy2) valid_q[2] <= valid_q[1];
      if (rdy3) valid_q[3] <= valid_q[2];
    end
  end

  // Stage 0: shifted dividend
  logic [49:0] u_d, u_q;
  assign u_d = {{2{time_ns_i[63]}}, time_ns_i[63:NsShift]} + EpochOffset;

  // Stage 1: quotient estimate from the top bits, low by at most one
  logic [51:0] est_prod;
  logic [19:0] qest1_d, qest1_q;
  logic [32:0] ulo1_q;
  assign est_prod = 52'(u_q[49:20]) * 52'(DayRecip);
  assign qest1_d  = est_prod[51:32];

  // Stage 2: back-multiply, only the low bits matter since the remainder is < 2^32
  logic [32:0] qd_d, qd_q;
  logic [19:0] qest2_q;
  logic [32:0] ulo2_q;
  assign qd_d = 33'(qest1_q) * 33'(NsDivisor);

  // Stage 3: single correction step
  logic [32:0] rem;
  days_t       days_d, days_q;
  assign rem    = ulo2_q - qd_q;
  assign days_d = days_t'(qest2_q) + days_t'(rem >= 33'(NsDivisor));

  always_ff @(posedge clk_i) begin
    if (rdy0) u_q <= u_d;
    if (rdy1) begin
      qest1_q <= qest1_d;
      ulo1_q  <= u_q[32:0];
    end
    if (rdy2) begin
      qd_q    <= qd_d;
      qest2_q <= qest1_q;
      ulo2_q  <= ulo1_q;
    end
    if (rdy3) days_q <= days_d;
  end

  assign in_ready_o  = rdy0;
  assign out_valid_o = valid_q[3];
  assign days_o      = days_q;

endmodule : tcd_day_div

`default_nettype wire

FILE: rtl/core/tcd_civil.sv
// Era, year of era, day of year and March-based month split into year, month and day.
`default_nettype none

module tcd_civil (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tcd_pkg::days_t  days_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tcd_pkg::year_t  year_o,
  output tcd_pkg::month_t month_o,
  output tcd_pkg::mday_t  day_o
);
  import tcd_pkg::*;

  localparam int unsigned DaysPerEra = 146097;
  localparam days_t       Era4Start  = days_t'(4 * DaysPerEra);
  localparam days_t       Era5Start  = days_t'(5 * DaysPerEra);
  localparam year_t       Era4Year   = year_t'(4 * 400);
  localparam year_t       Era5Year   = year_t'(5 * 400);

  // floor(x / c) = (x * ceil-ish reciprocal) >> 36, exact for x, c < 2^18
  localparam int unsigned RecipShift = 36;
  localparam logic [25:0] Recip1460  = 26'((64'd1 << RecipShift) / 1460 + 1);
  localparam logic [27:0] Recip365   = 28'((64'd1 << RecipShift) / 365 + 1);
  localparam logic [28:0] Recip153   = 29'((64'd1 << RecipShift) / 153 + 1);

  localparam logic [17:0] Cent1 = 18'd36524;
  localparam logic [17:0] Cent2 = 18'd73048;
  localparam logic [17:0] Cent3 = 18'd109572;
  localparam logic [17:0] Cent4 = 18'd146096;

  // First day of each March-based month within the year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  logic [5:0] valid_q;
  logic       rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !valid_q[5] || out_ready_i;
  assign rdy4 = !valid_q[4] || rdy5;
  assign rdy3 = !valid_q[3] || rdy4;
  assign rdy2 = !valid_q[2] || rdy3;
  assign rdy1 = !valid_q[1] || rdy2;
  assign rdy0 = !valid_q[0] || rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy0) valid_q[0] <= in_valid_i;
      if (rdy1) valid_q[1] <= valid_q[0];
      if (rdy2) valid_q[2] <= valid_q[1];
      if (rdy3) valid_q[3] <= valid_q[2];
      if (rdy4) valid_q[4] <= valid_q[3];
      if (rdy5) valid_q[5] <= valid_q[4];
    end
  end

  // Stage 0: era is only ever 4 or 5 over the input range
  logic        era5_0_d, era5_0_q;
  logic [17:0] doe0_d, doe0_q;
  assign era5_0_d = days_i >= Era5Start;
  assign doe0_d   = 18'(days_i - (era5_0_d ? Era5Start : Era4Start));

  // Stage 1: leap-day corrected day of era
  logic [43:0] p1460;
  logic [7:0]  q1460;
  logic [2:0]  q36524;
  logic [17:0] adj1_d, adj1_q, doe1_q;
  logic        era5_1_q;
  assign p1460  = 44'(doe0_q) * 44'(Recip1460);
  assign q1460  = p1460[43:36];
  assign q36524 = 3'(doe0_q >= Cent1) + 3'(doe0_q >= Cent2) + 3'(doe0_q >= Cent3)
                + 3'(doe0_q >= Cent4);
  assign adj1_d = doe0_q - 18'(q1460) + 18'(q36524) - 18'(doe0_q >= Cent4);

  // Stage 2: year of era
  logic [45:0] p365;
  logic [8:0]  yoe2_d, yoe2_q;
  logic [17:0] doe2_q;
  logic        era5_2_q;
  assign p365   = 46'(adj1_q) * 46'(Recip365);
  assign yoe2_d = p365[44:36];

  // Stage 3: day of year and year before the Jan/Feb fix-up
  logic [1:0]  q100;
  logic [17:0] yr_days;
  logic [8:0]  doy3_d, doy3_q;
  year_t       ybase3_d, ybase3_q;
  assign q100     = 2'(yoe2_q >= 9'd100) + 2'(yoe2_q >= 9'd200) + 2'(yoe2_q >= 9'd300);
  assign yr_days  = 18'(yoe2_q) * 18'd365 + 18'(yoe2_q[8:2]) - 18'(q100);
  assign doy3_d   = 9'(doe2_q - yr_days);
  assign ybase3_d = year_t'(yoe2_q) + (era5_2_q ? Era5Year : Era4Year);

  // Stage 4: March-based month
  logic [10:0] mp_num;
  logic [39:0] p153;
  logic [3:0]  mp4_d, mp4_q;
  logic [8:0]  doy4_q;
  year_t       ybase4_q;
  assign mp_num = 11'({doy3_q, 2'b00}) + 11'(doy3_q) + 11'd2;
  assign p153   = 40'(mp_num) * 40'(Recip153);
  assign mp4_d  = p153[39:36];

  // Stage 5: calendar fields
  logic   jan_feb;
  year_t  year_d, year_q;
  month_t month_d, month_q;
  mday_t  day_d, day_q;
  assign jan_feb = mp4_q >= 4'd10;
  assign day_d   = mday_t'(doy4_q - month_start(mp4_q) + 9'd1);
  assign month_d = jan_feb ? month_t'(mp4_q - 4'd9) : month_t'(mp4_q + 4'd3);
  assign year_d  = ybase4_q + year_t'(jan_feb);

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      era5_0_q <= era5_0_d;
      doe0_q   <= doe0_d;
    end
    if (rdy1) begin
      adj1_q   <= adj1_d;
      doe1_q   <= doe0_q;
      era5_1_q <= era5_0_q;
    end
    if (rdy2) begin
      yoe2_q   <= yoe2_d;
      doe2_q   <= doe1_q;
      era5_2_q <= era5_1_q;
    end
    if (rdy3) begin
      doy3_q   <= doy3_d;
      ybase3_q <= ybase3_d;
    end
    if (rdy4) begin
      mp4_q    <= mp4_d;
      doy4_q   <= doy3_q;
      ybase4_q <= ybase3_q;
    end
    if (rdy5) begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
    end
  end

  assign in_ready_o  = rdy0;
  assign out_valid_o = valid_q[5];
  assign year_o      = year_q;
  assign month_o     = month_q;
  assign day_o       = day_q;

endmodule : tcd_civil

`default_nettype wire

FILE: rtl/core/timestamp_to_civil_date_top.sv
// Top level: signed nanosecond timestamp to proleptic Gregorian year, month and day.
// Pipeline: 4 division stages followed by 6 calendar stages.
// Throughput: one item per cycle; each stage holds while the stage after it is full and stalled.
// Any stage without a valid item takes a new one, so bubbles close up under back-pressure.
// Reset: asynchronous active low, clears all valid bits; data registers are not reset.
`default_nettype none

module timestamp_to_civil_date_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [63:0]         time_ns_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcd_pkg::year_t      year_o,
  output tcd_pkg::month_t     month_o,
  output tcd_pkg::mday_t      day_o
);
  import tcd_pkg::*;

  logic  dd_valid, dd_ready;
  days_t dd_days;

  tcd_day_div u_day_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .time_ns_i   (time_ns_i),
    .out_valid_o (dd_valid),
    .out_ready_i (dd_ready),
    .days_o      (dd_days)
  );

  tcd_civil u_civil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dd_valid),
    .in_ready_o  (dd_ready),
    .days_i      (dd_days),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .year_o      (year_o),
    .month_o     (month_o),
    .day_o       (day_o)
  );

  // The input side only stalls when every stage is full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a full, blocked pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dd_valid |-> (dd_days >= ShiftedDaysMin && dd_days <= ShiftedDaysMax))
    else $error("shifted day count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (year_o >= YearMin && year_o <= YearMax && month_o >= 4'd1 &&
                     month_o <= 4'd12 && day_o >= 5'd1))
    else $error("calendar fields out of range");

endmodule : timestamp_to_civil_date_top

`default_nettype wire
